// ===== hw/rtl/scb_pkg.sv =====
// scb_pkg: types and constants shared by the stream capture buffer
// holds item and register layouts, opcode codes and register indexes
// depends on nothing
package scb_pkg;

	typedef enum logic [1:0] {
		OP_DATA    = 2'd0,
		OP_EOM     = 2'd1,
		OP_RD_DATA = 2'd2,
		OP_RD_META = 2'd3
	} op_t;

	// word selector within a metadata record
	localparam logic [1:0] SUB_HEAD  = 2'd0;
	localparam logic [1:0] SUB_TS_LO = 2'd1;
	localparam logic [1:0] SUB_TS_RP = 2'd2;
	localparam logic [1:0] SUB_TS_HI = 2'd3;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_STOP_ON_FULL    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_ON_EOF     = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_ON_ZLM     = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_ZLM_OPCODE = 8'd3;

	// record row: {timestamp high, timestamp low, opcode and size}
	localparam int REC_W = 96;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] word;
		logic [7:0]  msg_opcode;
		logic [23:0] msg_size;
		logic [63:0] timestamp;
		logic        eof;
		logic [9:0]  read_index;
		logic [1:0]  read_sub;
	} in_item_t;

	typedef struct packed {
		logic [31:0] out_word;
		logic        word_valid;
		logic        done_res;
		logic [31:0] data_count;
		logic [31:0] record_count;
		logic        data_full;
		logic        meta_full;
		logic [63:0] total_bytes;
	} out_item_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] wdata;
	} cfg_item_t;

endpackage

// ===== hw/rtl/scb_stream_if.sv =====
// scb_stream_if: valid/ready channel with a typed payload
// used for the item, result and register write channels; no dependencies
interface scb_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== hw/rtl/stream_capture_buffer.sv =====
// stream_capture_buffer: captures a message stream into a data word ram and a
// metadata record ram; depends on scb_pkg, scb_stream_if and scb_ram
// pipeline: stage 1 ram read, stage 2 result register; throughput is set by the
// single write and read port of each ram: one item per cycle unless results stall
// reset: registers clear at once, then both rams are zeroed one row a cycle up to
// max(DATA_WORDS, RECORDS) rows; no item is accepted during that pass
module stream_capture_buffer #(
	parameter int DATA_WORDS = 1024,
	parameter int RECORDS    = 256
) (
	input  logic clk,
	input  logic arst_n,
	scb_stream_if.sink   items,
	scb_stream_if.source results,
	scb_stream_if.sink   cfg
);
	import scb_pkg::*;

	localparam int DW_AW     = $clog2(DATA_WORDS);
	localparam int RC_AW     = $clog2(RECORDS);
	localparam int CLR_DEPTH = (DATA_WORDS > RECORDS) ? DATA_WORDS : RECORDS;
	localparam int CLR_W     = $clog2(CLR_DEPTH);

	localparam logic [31:0]      DW_CAP  = 32'(DATA_WORDS);
	localparam logic [31:0]      RC_CAP  = 32'(RECORDS);
	localparam logic [DW_AW-1:0] DP_LAST = DW_AW'(DATA_WORDS - 1);
	localparam logic [RC_AW-1:0] RP_LAST = RC_AW'(RECORDS - 1);
	localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_DEPTH - 1);

	// configuration
	logic       stop_on_full_q, stop_on_eof_q, stop_on_zlm_q;
	logic [7:0] stop_zlm_opcode_q;

	// capture state
	logic [DW_AW-1:0] data_ptr_q;
	logic [RC_AW-1:0] record_ptr_q;
	logic [31:0]      data_counter_q, record_counter_q;
	logic [63:0]      byte_total_q;
	logic             data_full_q, meta_full_q, data_off_q, record_off_q;

	// clearing pass
	logic             clearing_q;
	logic [CLR_W-1:0] clr_q;

	// pipeline
	logic        v_s1, v_s2;
	op_t         op_s1;
	logic [1:0]  sub_s1;
	logic        inrange_s1, done_s1;
	logic [31:0] word_s1;
	out_item_t   res_s2;

	logic        s2_free, s1_move, accept;
	in_item_t    it;
	op_t         op;
	logic        eom_live, counting, rc_step;
	logic [31:0] rc_next;
	logic        done_c;
	logic [31:0] out_word_c;

	logic             d_we, r_we;
	logic [DW_AW-1:0] d_waddr;
	logic [RC_AW-1:0] r_waddr;
	logic [31:0]      d_wdata;
	logic [REC_W-1:0] r_wdata, r_rdata;
	logic [31:0]      d_rdata;

	assign it      = items.data;
	assign op      = op_t'(it.opcode);
	assign s2_free = !v_s2 || results.ready;
	assign s1_move = v_s1 && s2_free;
	assign items.ready = !clearing_q && (!v_s1 || s2_free);
	assign accept  = items.valid && items.ready;
	assign cfg.ready = 1'b1;

	assign eom_live = (op == OP_EOM) && !it.eof;
	assign counting = !stop_on_full_q ||
		(data_counter_q != DW_CAP && record_counter_q != RC_CAP);
	assign rc_step  = !stop_on_full_q || record_counter_q != RC_CAP;
	assign rc_next  = rc_step ? record_counter_q + 32'd1 : record_counter_q;
	assign done_c   = (it.eof && stop_on_eof_q) ||
		(it.msg_size == 24'd0 && it.msg_opcode == stop_zlm_opcode_q && stop_on_zlm_q);

	// ram write ports: clearing pass or capture
	always_comb begin
		d_we    = 1'b0;
		d_waddr = data_ptr_q;
		d_wdata = it.word;
		r_we    = 1'b0;
		r_waddr = record_ptr_q;
		r_wdata = {it.timestamp[63:32], it.timestamp[31:0], it.msg_opcode, it.msg_size};
		if (clearing_q) begin
			d_we    = 32'(clr_q) < DW_CAP;
			d_waddr = DW_AW'(clr_q);
			d_wdata = '0;
			r_we    = 32'(clr_q) < RC_CAP;
			r_waddr = RC_AW'(clr_q);
			r_wdata = '0;
		end else if (accept) begin
			d_we = (op == OP_DATA) && !record_off_q && !data_off_q;
			r_we = eom_live && !record_off_q;
		end
	end

	scb_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_data_ram (
		.clk   (clk),
		.we    (d_we),
		.waddr (d_waddr),
		.wdata (d_wdata),
		.re    (accept && op == OP_RD_DATA),
		.raddr (DW_AW'(it.read_index)),
		.rdata (d_rdata)
	);

	scb_ram #(.WIDTH(REC_W), .DEPTH(RECORDS)) u_record_ram (
		.clk   (clk),
		.we    (r_we),
		.waddr (r_waddr),
		.wdata (r_wdata),
		.re    (accept && op == OP_RD_META),
		.raddr (RC_AW'(it.read_index)),
		.rdata (r_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + CLR_W'(1);
			if (clr_q == CLR_LAST) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_on_full_q    <= 1'b0;
			stop_on_eof_q     <= 1'b1;
			stop_on_zlm_q     <= 1'b0;
			stop_zlm_opcode_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				CFG_STOP_ON_FULL:    stop_on_full_q    <= cfg.data.wdata[0];
				CFG_STOP_ON_EOF:     stop_on_eof_q     <= cfg.data.wdata[0];
				CFG_STOP_ON_ZLM:     stop_on_zlm_q     <= cfg.data.wdata[0];
				CFG_STOP_ZLM_OPCODE: stop_zlm_opcode_q <= cfg.data.wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_ptr_q       <= '0;
			record_ptr_q     <= '0;
			data_counter_q   <= '0;
			record_counter_q <= '0;
			byte_total_q     <= '0;
			data_full_q      <= 1'b0;
			meta_full_q      <= 1'b0;
			data_off_q       <= 1'b0;
			record_off_q     <= 1'b0;
		end else if (accept) begin
			if (op == OP_DATA) begin
				if (counting) begin
					data_counter_q <= data_counter_q + 32'd1;
				end
				data_ptr_q <= (data_ptr_q == DP_LAST) ? '0 : data_ptr_q + DW_AW'(1);
			end else if (eom_live) begin
				byte_total_q     <= byte_total_q + 64'(it.msg_size);
				record_counter_q <= rc_next;
				record_ptr_q <= (record_ptr_q == RP_LAST) ? '0 : record_ptr_q + RC_AW'(1);
				if (data_counter_q >= DW_CAP) begin
					data_full_q <= 1'b1;
					if (stop_on_full_q) begin
						data_off_q <= 1'b1;
					end
				end
				// checked against the count after this record
				if (rc_next == RC_CAP) begin
					meta_full_q <= 1'b1;
					if (stop_on_full_q) begin
						record_off_q <= 1'b1;
					end
				end
			end
		end
	end

	// stage 1: ram access in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (s1_move) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= op;
			sub_s1  <= it.read_sub;
			word_s1 <= it.word;
			done_s1 <= (op == OP_EOM) && done_c;
			inrange_s1 <= (op == OP_RD_DATA) ? (32'(it.read_index) < DW_CAP)
				: (32'(it.read_index) < RC_CAP);
		end
	end

	always_comb begin
		case (op_s1)
			OP_DATA:    out_word_c = word_s1;
			OP_EOM:     out_word_c = '0;
			OP_RD_DATA: out_word_c = inrange_s1 ? d_rdata : '0;
			OP_RD_META: begin
				case (sub_s1)
					SUB_HEAD:  out_word_c = r_rdata[31:0];
					SUB_TS_LO: out_word_c = r_rdata[63:32];
					SUB_TS_RP: out_word_c = r_rdata[63:32];
					SUB_TS_HI: out_word_c = r_rdata[95:64];
					default:   out_word_c = '0;
				endcase
				if (!inrange_s1) begin
					out_word_c = '0;
				end
			end
			default:    out_word_c = '0;
		endcase
	end

	// stage 2: result register; state registers hold the post-item values here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s1_move) begin
			v_s2 <= 1'b1;
		end else if (results.ready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			res_s2.out_word     <= out_word_c;
			res_s2.word_valid   <= op_s1 != OP_EOM;
			res_s2.done_res     <= done_s1;
			res_s2.data_count   <= data_counter_q;
			res_s2.record_count <= record_counter_q;
			res_s2.data_full    <= data_full_q;
			res_s2.meta_full    <= meta_full_q;
			res_s2.total_bytes  <= byte_total_q;
		end
	end

	assign results.valid = v_s2;
	assign results.data  = res_s2;
endmodule

// ===== hw/rtl/scb_ram.sv =====
// scb_ram: generic single write port, single read port ram
// registered read; no dependencies
module scb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== tb/sv/scb_capture_checker.sv =====
// scb_capture_checker: watches the item, result and register channels of the capture buffer
// keeps its own copy of both stores, counters and flags and compares every result in order
// depends on scb_pkg
module scb_capture_checker #(
	parameter int DATA_WORDS = 1024,
	parameter int RECORDS    = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  scb_pkg::in_item_t  in_data,
	input  logic               out_valid,
	input  logic               out_ready,
	input  scb_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  scb_pkg::cfg_item_t cfg_data,
	output int                 errors,
	output int                 pending,
	output int                 compared
);
	import scb_pkg::*;

	logic [31:0] words_mem [DATA_WORDS];
	logic [31:0] records_mem [4 * RECORDS];
	int unsigned wr_ptr;
	int unsigned rec_ptr;
	logic [31:0] word_cnt;
	logic [31:0] rec_cnt;
	logic [63:0] bytes_sum;
	logic        words_full;
	logic        recs_full;
	logic        words_frozen;
	logic        recs_frozen;
	logic        lead_mode;
	logic        eof_stop;
	logic        zlm_stop;
	logic [7:0]  zlm_code;

	out_item_t awaited_q [$];
	int fails = 0;
	int seen = 0;
	int owed = 0;

	assign errors   = fails;
	assign pending  = owed;
	assign compared = seen;

	// advances the shadow state by one item and returns the result it should produce
	function automatic out_item_t capture_outcome(input in_item_t it);
		out_item_t   r;
		int unsigned rec_base;
		r = '0;
		case (it.opcode)
			OP_DATA: begin
				if (!recs_frozen && !words_frozen)
					words_mem[wr_ptr] = it.word;
				// leading capture stops counting once either store is at capacity
				if (!lead_mode || (word_cnt != DATA_WORDS && rec_cnt != RECORDS))
					word_cnt++;
				wr_ptr = (wr_ptr >= DATA_WORDS - 1) ? 0 : wr_ptr + 1;
				r.out_word   = it.word;
				r.word_valid = 1'b1;
			end
			OP_EOM: begin
				if (!it.eof) begin
					bytes_sum += 64'(it.msg_size);
					if (!recs_frozen) begin
						rec_base = rec_ptr * 4;
						records_mem[rec_base + int'(SUB_HEAD)]  = {it.msg_opcode, it.msg_size};
						records_mem[rec_base + int'(SUB_TS_LO)] = it.timestamp[31:0];
						records_mem[rec_base + int'(SUB_TS_RP)] = it.timestamp[31:0];
						records_mem[rec_base + int'(SUB_TS_HI)] = it.timestamp[63:32];
					end
					if (!lead_mode || rec_cnt != RECORDS)
						rec_cnt++;
					rec_ptr = (rec_ptr >= RECORDS - 1) ? 0 : rec_ptr + 1;
					if (word_cnt >= DATA_WORDS) begin
						words_full = 1'b1;
						if (lead_mode)
							words_frozen = 1'b1;
					end
					if (rec_cnt == RECORDS) begin
						recs_full = 1'b1;
						if (lead_mode)
							recs_frozen = 1'b1;
					end
				end
				r.done_res = (it.eof && eof_stop) ||
					(it.msg_size == '0 && it.msg_opcode == zlm_code && zlm_stop);
			end
			OP_RD_DATA: begin
				r.out_word   = (it.read_index < DATA_WORDS) ? words_mem[it.read_index] : '0;
				r.word_valid = 1'b1;
			end
			OP_RD_META: begin
				r.out_word = (it.read_index < RECORDS) ?
					records_mem[int'(it.read_index) * 4 + int'(it.read_sub)] : '0;
				r.word_valid = 1'b1;
			end
			default: ;
		endcase
		r.data_count   = word_cnt;
		r.record_count = rec_cnt;
		r.data_full    = words_full;
		r.meta_full    = recs_full;
		r.total_bytes  = bytes_sum;
		return r;
	endfunction

	task automatic check_field(input string fld, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			fails++;
			if (fails <= 40)
				$display("%0t %s mismatch: expected %0h, got %0h", $time, fld, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			for (int i = 0; i < DATA_WORDS; i++)
				words_mem[i] = '0;
			for (int i = 0; i < 4 * RECORDS; i++)
				records_mem[i] = '0;
			wr_ptr       = 0;
			rec_ptr      = 0;
			word_cnt     = '0;
			rec_cnt      = '0;
			bytes_sum    = '0;
			words_full   = 1'b0;
			recs_full    = 1'b0;
			words_frozen = 1'b0;
			recs_frozen  = 1'b0;
			lead_mode    = 1'b0;
			eof_stop     = 1'b1;
			zlm_stop     = 1'b0;
			zlm_code     = '0;
			awaited_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_data.index)
					CFG_STOP_ON_FULL:    lead_mode = cfg_data.wdata[0];
					CFG_STOP_ON_EOF:     eof_stop  = cfg_data.wdata[0];
					CFG_STOP_ON_ZLM:     zlm_stop  = cfg_data.wdata[0];
					CFG_STOP_ZLM_OPCODE: zlm_code  = cfg_data.wdata[7:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				awaited_q.push_back(capture_outcome(in_data));
			if (out_valid && out_ready) begin
				if (awaited_q.size() == 0) begin
					fails++;
					if (fails <= 40)
						$display("%0t unexpected result: expected none, got out_word %0h",
							$time, out_data.out_word);
				end else begin
					want = awaited_q.pop_front();
					seen++;
					check_field("out_word", 64'(want.out_word), 64'(out_data.out_word));
					check_field("word_valid", 64'(want.word_valid), 64'(out_data.word_valid));
					check_field("done_res", 64'(want.done_res), 64'(out_data.done_res));
					check_field("data_count", 64'(want.data_count), 64'(out_data.data_count));
					check_field("record_count", 64'(want.record_count),
						64'(out_data.record_count));
					check_field("data_full", 64'(want.data_full), 64'(out_data.data_full));
					check_field("meta_full", 64'(want.meta_full), 64'(out_data.meta_full));
					check_field("total_bytes", want.total_bytes, out_data.total_bytes);
				end
			end
		end
		owed = awaited_q.size();
	end

endmodule

// ===== tb/sv/tb.sv =====
// tb: top of the capture buffer testbench; drives items and register writes, random stalls
// on both sides, and reports the verdict from the checker's counts
// depends on scb_pkg, scb_stream_if, stream_capture_buffer and scb_capture_checker
module tb;
	import scb_pkg::*;

	localparam int DATA_WORDS   = 1024;
	localparam int RECORDS      = 256;
	localparam int IDLE_PCT     = 11;
	localparam int LIMIT_CYCLES = 400000;
	// indexes past the last register, writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 8'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST  = 8'hff;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   calm = 1'b0;
	int   sent = 0;
	int   words_sent = 0;
	int   msgs_sent = 0;
	int   reads_sent = 0;
	int   res_count = 0;
	logic [7:0] zlm_target = 8'h00;
	int   chk_errors;
	int   chk_pending;
	int   chk_compared;

	scb_stream_if #(.T(in_item_t))  item_if ();
	scb_stream_if #(.T(out_item_t)) res_if ();
	scb_stream_if #(.T(cfg_item_t)) cfg_if ();

	stream_capture_buffer #(
		.DATA_WORDS(DATA_WORDS),
		.RECORDS(RECORDS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.items(item_if),
		.results(res_if),
		.cfg(cfg_if)
	);

	scb_capture_checker #(
		.DATA_WORDS(DATA_WORDS),
		.RECORDS(RECORDS)
	) u_chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(item_if.valid),
		.in_ready(item_if.ready),
		.in_data(item_if.data),
		.out_valid(res_if.valid),
		.out_ready(res_if.ready),
		.out_data(res_if.data),
		.cfg_valid(cfg_if.valid),
		.cfg_ready(cfg_if.ready),
		.cfg_data(cfg_if.data),
		.errors(chk_errors),
		.pending(chk_pending),
		.compared(chk_compared)
	);

	always #2 clk = ~clk;

	initial begin
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			res_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		if (res_if.valid && res_if.ready)
			res_count <= res_count + 1;
	end

	// every field random, so unused fields of an item toggle too
	function automatic in_item_t scrambled_item(input op_t op);
		in_item_t it;
		it.opcode     = op;
		it.word       = $urandom;
		it.msg_opcode = 8'($urandom);
		it.msg_size   = 24'($urandom);
		it.timestamp  = {$urandom, $urandom};
		it.eof        = 1'($urandom);
		it.read_index = 10'($urandom);
		it.read_sub   = 2'($urandom);
		return it;
	endfunction

	function automatic in_item_t data_item(input logic [31:0] w);
		in_item_t it;
		it = scrambled_item(OP_DATA);
		it.word = w;
		return it;
	endfunction

	function automatic in_item_t eom_item(input logic [7:0] mop, input logic [23:0] size,
		input logic [63:0] ts, input logic eof);
		in_item_t it;
		it = scrambled_item(OP_EOM);
		it.msg_opcode = mop;
		it.msg_size   = size;
		it.timestamp  = ts;
		it.eof        = eof;
		return it;
	endfunction

	function automatic in_item_t read_item(input op_t op, input logic [9:0] idx,
		input logic [1:0] sub);
		in_item_t it;
		it = scrambled_item(op);
		it.read_index = idx;
		it.read_sub   = sub;
		return it;
	endfunction

	task automatic send_item(input in_item_t it);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			item_if.valid <= 1'b0;
			@(posedge clk);
		end
		item_if.valid <= 1'b1;
		item_if.data  <= it;
		do
			@(posedge clk);
		while (!item_if.ready);
		sent++;
		if (it.opcode == OP_DATA)
			words_sent++;
		else if (it.opcode == OP_EOM && !it.eof)
			msgs_sent++;
		else if (it.opcode != OP_EOM)
			reads_sent++;
	endtask

	// a message: data words with the odd stray item mixed in, then its end item
	task automatic send_message(input int n_words);
		in_item_t it;
		in_item_t noise;
		for (int i = 0; i < n_words; i++) begin
			if ($urandom_range(0, 23) == 0) begin
				noise = scrambled_item(op_t'($urandom_range(0, 3)));
				if (noise.opcode[1] && $urandom_range(0, 3) != 0)
					noise.read_index = 10'($urandom_range(0, RECORDS - 1));
				send_item(noise);
			end
			send_item(data_item($urandom));
		end
		it = eom_item(8'($urandom), 24'($urandom), {$urandom, $urandom}, 1'b0);
		if ($urandom_range(0, 1) == 0)
			it.msg_size = 24'($urandom_range(0, 1500));
		case ($urandom_range(0, 19))
			0: it.eof = 1'b1;
			1, 2: begin
				it.msg_size   = '0;
				it.msg_opcode = zlm_target;
			end
			3: it.msg_size = '0;
			default: ;
		endcase
		send_item(it);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= '{index: idx, wdata: val};
		do
			@(posedge clk);
		while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		item_if.valid <= 1'b0;
		while (res_count != sent)
			@(posedge clk);
	endtask

	initial begin
		item_if.valid <= 1'b0;
		item_if.data  <= '0;
		cfg_if.valid  <= 1'b0;
		cfg_if.data   <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		write_reg(CFG_IDX_SPARE, 8'($urandom));
		write_reg(CFG_IDX_LAST, 8'($urandom));
		write_reg(CFG_STOP_ON_FULL, {7'($urandom), 1'b0});
		write_reg(CFG_STOP_ON_EOF, {7'($urandom), 1'b1});
		write_reg(CFG_STOP_ON_ZLM, {7'($urandom), 1'b1});
		zlm_target = 8'hff;
		write_reg(CFG_STOP_ZLM_OPCODE, zlm_target);

		send_item(data_item(32'h0000_0000));
		send_item(data_item(32'hffff_ffff));
		send_item(data_item(32'haaaa_aaaa));
		send_item(data_item(32'h5555_5555));
		send_item(eom_item(8'hff, 24'hff_ffff, '1, 1'b0));
		// zero length but not the stop opcode
		send_item(eom_item(8'h00, 24'h00_0000, '0, 1'b0));
		send_item(eom_item(8'hff, 24'h00_0000, 64'h0123_4567_89ab_cdef, 1'b0));
		// end of file captures nothing
		send_item(eom_item(8'h5a, 24'h00_0040, {$urandom, $urandom}, 1'b1));
		send_item(eom_item(8'hff, 24'h00_0000, '1, 1'b1));
		send_item(read_item(OP_RD_META, 10'd0, SUB_HEAD));
		send_item(read_item(OP_RD_META, 10'd0, SUB_TS_LO));
		send_item(read_item(OP_RD_META, 10'd0, SUB_TS_RP));
		send_item(read_item(OP_RD_META, 10'd0, SUB_TS_HI));
		send_item(read_item(OP_RD_META, 10'd1, SUB_TS_HI));
		send_item(read_item(OP_RD_META, 10'd2, SUB_TS_LO));
		send_item(read_item(OP_RD_META, 10'(RECORDS - 1), SUB_TS_RP));
		// record index past the store reads zero
		send_item(read_item(OP_RD_META, 10'(RECORDS), SUB_HEAD));
		send_item(read_item(OP_RD_META, 10'h3ff, SUB_TS_HI));
		send_item(read_item(OP_RD_DATA, 10'd0, 2'($urandom)));
		send_item(read_item(OP_RD_DATA, 10'd1, 2'($urandom)));
		send_item(read_item(OP_RD_DATA, 10'd3, 2'($urandom)));
		send_item(read_item(OP_RD_DATA, 10'h3ff, 2'($urandom)));

		// trailing capture until the data ring has wrapped
		drain();
		write_reg(CFG_STOP_ON_EOF, {7'($urandom), 1'b0});
		zlm_target = 8'h00;
		write_reg(CFG_STOP_ZLM_OPCODE, zlm_target);
		while (words_sent < DATA_WORDS + 16) begin
			calm = (sent < 400);
			send_message($urandom_range(0, 16));
		end
		calm = 1'b0;

		// leading capture: short messages until the record store fills and freezes
		drain();
		write_reg(CFG_STOP_ON_FULL, {7'($urandom), 1'b1});
		write_reg(CFG_STOP_ON_EOF, {7'($urandom), 1'b1});
		write_reg(CFG_STOP_ON_ZLM, {7'($urandom), 1'b0});
		zlm_target = 8'($urandom);
		write_reg(CFG_STOP_ZLM_OPCODE, zlm_target);
		while (msgs_sent < RECORDS + 16)
			send_message($urandom_range(0, 1));

		// back to trailing with the stores frozen
		drain();
		write_reg(CFG_STOP_ON_FULL, {7'($urandom), 1'b0});
		write_reg(CFG_STOP_ON_ZLM, {7'($urandom), 1'b1});
		for (int m = 0; m < 10; m++)
			send_message($urandom_range(0, 4));

		drain();
		repeat (8) @(posedge clk);
		$display("summary: %0d items sent (%0d data words, %0d records, %0d reads), %0d compared",
			sent, words_sent, msgs_sent, reads_sent, chk_compared);
		$display("summary: trailing wrap, leading fill and freeze, eof and zero-length stops");
		if (chk_errors == 0 && chk_pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#(LIMIT_CYCLES * 4);
		$display("%0t timeout with %0d of %0d results seen", $time, res_count, sent);
		$display("DONE: errors detected");
		$finish;
	end

endmodule
